// ----- hw/rtl/assert_macros.svh -----
// Assertion macros shared by the checker files.
// No dependencies; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked on every clock edge outside reset.
`define VCSP_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// Check that stays armed through reset.
`define VCSP_ASSERT_ALWAYS(label, prop, msg) \
   label: assert property (@(posedge clock) prop) else $error(msg);

`endif

// ----- hw/rtl/vcsp_pkg.sv -----
// Shared types, codes and constant tables of the command stream player.
// No dependencies.
package vcsp_pkg;

   localparam logic [7:0] CmdWrite = 8'hB3;
   localparam logic [7:0] CmdEnd   = 8'h66;

   localparam int SilenceLength   = 42;
   localparam int StepWidth       = $clog2(SilenceLength + 1);
   localparam int QueueDepth      = 4;
   localparam int QueuePtrWidth   = $clog2(QueueDepth);
   localparam int QueueCountWidth = $clog2(QueueDepth + 1);

   typedef enum logic [1:0] {
      KIND_BYTE = 2'd0,
      KIND_STOP = 2'd1,
      KIND_PLAY = 2'd2
   } kind_type;

   typedef enum logic [1:0] {
      EV_WRITE = 2'd0,
      EV_WAIT  = 2'd1,
      EV_SEEK  = 2'd2,
      EV_STOP  = 2'd3
   } event_type;

   typedef enum logic [1:0] {
      PH_CMD   = 2'd0,
      PH_INDEX = 2'd1,
      PH_VALUE = 2'd2
   } phase_type;

   typedef enum logic [1:0] {
      JOB_WRITE   = 2'd0,
      JOB_WAIT    = 2'd1,
      JOB_SEEK    = 2'd2,
      JOB_SILENCE = 2'd3
   } job_kind_type;

   // One classified request, as handed from the front to the back.
   typedef struct packed {
      job_kind_type kind;
      logic         stop;
      logic [7:0]   offset;
      logic [7:0]   value;
      logic [31:0]  seek;
   } job_type;

   // Queue handshake between front/back and the queue.
   typedef struct packed {
      logic push;
      logic pop;
   } queue_ctrl_type;

   typedef struct packed {
      logic full;
      logic not_empty;
   } queue_stat_type;

   // Write index to register offset; zero means unmapped or out of range.
   function automatic logic [7:0] reg_map(input logic [7:0] idx);
      logic [7:0] off;
      case (idx)
         8'h00: off = 8'h60;  8'h01: off = 8'h62;  8'h02: off = 8'h63;
         8'h03: off = 8'h64;  8'h04: off = 8'h65;  8'h06: off = 8'h68;
         8'h07: off = 8'h69;  8'h08: off = 8'h6C;  8'h09: off = 8'h6D;
         8'h0A: off = 8'h70;  8'h0B: off = 8'h72;  8'h0C: off = 8'h73;
         8'h0D: off = 8'h74;  8'h0E: off = 8'h75;  8'h10: off = 8'h78;
         8'h11: off = 8'h79;  8'h12: off = 8'h7C;  8'h13: off = 8'h7D;
         8'h14: off = 8'h80;  8'h15: off = 8'h81;  8'h16: off = 8'h84;
         8'h20: off = 8'h90;  8'h21: off = 8'h91;  8'h22: off = 8'h92;
         8'h23: off = 8'h93;  8'h24: off = 8'h94;  8'h25: off = 8'h95;
         8'h26: off = 8'h96;  8'h27: off = 8'h97;  8'h28: off = 8'h98;
         8'h29: off = 8'h99;  8'h2A: off = 8'h9A;  8'h2B: off = 8'h9B;
         8'h2C: off = 8'h9C;  8'h2D: off = 8'h9D;  8'h2E: off = 8'h9E;
         8'h2F: off = 8'h9F;
         default: off = 8'h00;
      endcase
      return off;
   endfunction

   // Silence sequence: register offset per step.
   function automatic logic [7:0] silence_offset(input logic [StepWidth-1:0] step);
      logic [7:0] off;
      case (step)
         6'd0:  off = 8'h84;  6'd1:  off = 8'h60;  6'd2:  off = 8'h62;
         6'd3:  off = 8'h63;  6'd4:  off = 8'h64;  6'd5:  off = 8'h65;
         6'd6:  off = 8'h68;  6'd7:  off = 8'h69;  6'd8:  off = 8'h6C;
         6'd9:  off = 8'h6D;  6'd10: off = 8'h70;  6'd11: off = 8'h72;
         6'd12: off = 8'h73;  6'd13: off = 8'h74;  6'd14: off = 8'h75;
         6'd15: off = 8'h78;  6'd16: off = 8'h79;  6'd17: off = 8'h7C;
         6'd18: off = 8'h7D;  6'd19: off = 8'h80;  6'd20: off = 8'h81;
         6'd21: off = 8'h84;  6'd22: off = 8'h90;  6'd23: off = 8'h91;
         6'd24: off = 8'h92;  6'd25: off = 8'h93;  6'd26: off = 8'h94;
         6'd27: off = 8'h95;  6'd28: off = 8'h96;  6'd29: off = 8'h97;
         6'd30: off = 8'h98;  6'd31: off = 8'h99;  6'd32: off = 8'h9A;
         6'd33: off = 8'h9B;  6'd34: off = 8'h9C;  6'd35: off = 8'h9D;
         6'd36: off = 8'h9E;  6'd37: off = 8'h9F;  6'd38: off = 8'h74;
         6'd39: off = 8'h80;  6'd40: off = 8'h81;  6'd41: off = 8'h84;
         default: off = 8'h00;
      endcase
      return off;
   endfunction

   // Silence sequence: value per step (zero except the closing writes).
   function automatic logic [7:0] silence_value(input logic [StepWidth-1:0] step);
      logic [7:0] val;
      case (step)
         6'd38:   val = 8'h80;
         6'd39:   val = 8'h77;
         6'd40:   val = 8'hFF;
         6'd41:   val = 8'h80;
         default: val = 8'h00;
      endcase
      return val;
   endfunction

endpackage

// ----- hw/rtl/vcsp_front.sv -----
// Front end: takes requests, tracks play/parse state, emits jobs.
// Depends on vcsp_pkg.
module vcsp_front (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_ready,
   input  logic [1:0]               req_kind,
   input  logic [7:0]               req_stream_byte,
   input  logic                     csr_we,
   input  logic [31:0]              csr_wdata,
   input  vcsp_pkg::queue_stat_type q_stat,
   output logic                     q_push,
   output vcsp_pkg::job_type        q_job
);
   import vcsp_pkg::*;

   logic        playing_ff, playing_in;
   phase_type   phase_ff, phase_in;
   logic [7:0]  pending_ff, pending_in;
   logic [31:0] loop_ff;
   logic        accept;
   logic [7:0]  mapped;

   assign req_ready = !q_stat.full;
   assign accept    = req_valid && req_ready;
   assign mapped    = reg_map(pending_ff);

   // next state
   always_comb begin
      playing_in = playing_ff;
      phase_in   = phase_ff;
      pending_in = pending_ff;
      if (accept) begin
         unique case (req_kind)
            KIND_STOP: begin
               playing_in = 1'b0;
               phase_in   = PH_CMD;
            end
            KIND_PLAY: begin
               playing_in = 1'b1;
               phase_in   = PH_CMD;
            end
            KIND_BYTE: begin
               if (playing_ff) begin
                  unique case (phase_ff)
                     PH_INDEX: begin
                        pending_in = req_stream_byte;
                        phase_in   = PH_VALUE;
                     end
                     PH_VALUE: phase_in = PH_CMD;
                     default: begin
                        if (req_stream_byte == CmdWrite) begin
                           phase_in = PH_INDEX;
                        end else begin
                           phase_in = PH_CMD;
                           if (req_stream_byte == CmdEnd && loop_ff == '0) begin
                              playing_in = 1'b0;
                           end
                        end
                     end
                  endcase
               end
            end
            default: ;
         endcase
      end
   end

   // job emission
   always_comb begin
      q_push        = 1'b0;
      q_job.kind    = JOB_WAIT;
      q_job.stop    = 1'b0;
      q_job.offset  = mapped;
      q_job.value   = req_stream_byte;
      q_job.seek    = loop_ff;
      if (accept) begin
         unique case (req_kind)
            KIND_STOP: begin
               q_push     = 1'b1;
               q_job.kind = JOB_SILENCE;
               q_job.stop = 1'b1;
            end
            KIND_PLAY: begin
               q_push     = 1'b1;
               q_job.kind = JOB_SILENCE;
            end
            KIND_BYTE: begin
               if (playing_ff) begin
                  unique case (phase_ff)
                     PH_INDEX: ;
                     PH_VALUE: begin
                        q_push     = (mapped != 8'h00);
                        q_job.kind = JOB_WRITE;
                     end
                     default: begin
                        if (req_stream_byte == CmdEnd) begin
                           q_push = 1'b1;
                           if (loop_ff != '0) begin
                              q_job.kind = JOB_SEEK;
                           end else begin
                              q_job.kind = JOB_SILENCE;
                              q_job.stop = 1'b1;
                           end
                        end else if (req_stream_byte != CmdWrite) begin
                           q_push = 1'b1;
                        end
                     end
                  endcase
               end
            end
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         playing_ff <= 1'b0;
         phase_ff   <= PH_CMD;
         pending_ff <= 8'h00;
         loop_ff    <= '0;
      end else begin
         playing_ff <= playing_in;
         phase_ff   <= phase_in;
         pending_ff <= pending_in;
         if (csr_we) begin
            loop_ff <= csr_wdata;
         end
      end
   end

endmodule

// ----- hw/rtl/vcsp_queue.sv -----
// Short job queue between front and back, flop based.
// Depends on vcsp_pkg.
module vcsp_queue (
   input  logic                     clock,
   input  logic                     reset,
   input  vcsp_pkg::queue_ctrl_type ctrl,
   input  vcsp_pkg::job_type        push_job,
   output vcsp_pkg::queue_stat_type stat,
   output vcsp_pkg::job_type        head_job
);
   import vcsp_pkg::*;

   job_type                    entry_ff [QueueDepth];
   logic [QueuePtrWidth-1:0]   wptr_ff, rptr_ff;
   logic [QueueCountWidth-1:0] count_ff, count_in;
   logic                       do_push, do_pop;

   assign stat.full      = (count_ff == QueueCountWidth'(QueueDepth));
   assign stat.not_empty = (count_ff != '0);
   assign head_job       = entry_ff[rptr_ff];
   assign do_push        = ctrl.push && !stat.full;
   assign do_pop         = ctrl.pop && stat.not_empty;

   always_comb begin
      count_in = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + QueueCountWidth'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - QueueCountWidth'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff  <= '0;
         rptr_ff  <= '0;
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
         if (do_push) begin
            wptr_ff <= wptr_ff + QueuePtrWidth'(1);
         end
         if (do_pop) begin
            rptr_ff <= rptr_ff + QueuePtrWidth'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wptr_ff] <= push_job;
      end
   end

endmodule

// ----- hw/rtl/vcsp_back.sv -----
// Back end: expands queued jobs into responses through an output register.
// Depends on vcsp_pkg.
module vcsp_back (
   input  logic                     clock,
   input  logic                     reset,
   input  vcsp_pkg::queue_stat_type q_stat,
   input  vcsp_pkg::job_type        q_job,
   output logic                     q_pop,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output logic [1:0]               rsp_event_res,
   output logic [7:0]               rsp_reg_offset,
   output logic [7:0]               rsp_reg_value,
   output logic [31:0]              rsp_seek_offset,
   output logic                     rsp_last
);
   import vcsp_pkg::*;

   logic [StepWidth-1:0] step_ff, step_in;
   logic                 valid_ff, valid_in;
   event_type            event_ff, event_in;
   logic [7:0]           offset_ff, offset_in;
   logic [7:0]           value_ff, value_in;
   logic [31:0]          seek_ff, seek_in;
   logic                 last_ff, last_in;
   logic                 advance;
   logic                 done;
   logic                 in_silence;

   assign advance    = q_stat.not_empty && (!valid_ff || rsp_ready);
   assign in_silence = (step_ff < StepWidth'(SilenceLength));

   // current result of the head job
   always_comb begin
      event_in  = EV_WRITE;
      offset_in = 8'h00;
      value_in  = 8'h00;
      seek_in   = '0;
      done      = 1'b1;
      unique case (q_job.kind)
         JOB_WRITE: begin
            offset_in = q_job.offset;
            value_in  = q_job.value;
         end
         JOB_WAIT: event_in = EV_WAIT;
         JOB_SEEK: begin
            event_in = EV_SEEK;
            seek_in  = q_job.seek;
         end
         default: begin
            if (in_silence) begin
               offset_in = silence_offset(step_ff);
               value_in  = silence_value(step_ff);
               done      = !q_job.stop && (step_ff == StepWidth'(SilenceLength - 1));
            end else begin
               event_in = EV_STOP;
            end
         end
      endcase
      last_in = done;
   end

   always_comb begin
      q_pop    = advance && done;
      step_in  = step_ff;
      valid_in = valid_ff && !rsp_ready;
      if (advance) begin
         valid_in = 1'b1;
         step_in  = done ? '0 : step_ff + StepWidth'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff  <= '0;
         valid_ff <= 1'b0;
      end else begin
         step_ff  <= step_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         event_ff  <= event_in;
         offset_ff <= offset_in;
         value_ff  <= value_in;
         seek_ff   <= seek_in;
         last_ff   <= last_in;
      end
   end

   assign rsp_valid       = valid_ff;
   assign rsp_event_res   = event_ff;
   assign rsp_reg_offset  = offset_ff;
   assign rsp_reg_value   = value_ff;
   assign rsp_seek_offset = seek_ff;
   assign rsp_last        = last_ff;

endmodule

// ----- hw/rtl/vgm_command_stream_player_core.sv -----
// An accepted request passes through the job queue and the back end's output
// register. Throughput, while rsp_ready is high: one request per cycle while
// each makes at most one response; a stop/play/end-of-data silence makes 42 or
// 43 responses, one per cycle, paced by the step counter. A 4-deep job queue
// decouples the two ends. Reset (synchronous, active high): stopped, parser
// expects a command byte, loop offset zero, queue and output register empty.
module vgm_command_stream_player_core (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [1:0]  req_kind,
   input  logic [7:0]  req_stream_byte,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [1:0]  rsp_event_res,
   output logic [7:0]  rsp_reg_offset,
   output logic [7:0]  rsp_reg_value,
   output logic [31:0] rsp_seek_offset,
   output logic        rsp_last,
   input  logic        csr_we,
   input  logic [31:0] csr_wdata
);
   import vcsp_pkg::*;

   // Front -> queue: one job per request that makes any response.
   queue_ctrl_type q_ctrl;
   queue_stat_type q_stat;
   job_type        push_job;
   job_type        head_job;
   logic           q_push;
   logic           q_pop;

   assign q_ctrl.push = q_push;
   assign q_ctrl.pop  = q_pop;

   // Parser: holds play flag, parse phase, pending index and loop offset.
   vcsp_front u_front (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_kind        (req_kind),
      .req_stream_byte (req_stream_byte),
      .csr_we          (csr_we),
      .csr_wdata       (csr_wdata),
      .q_stat          (q_stat),
      .q_push          (q_push),
      .q_job           (push_job)
   );

   vcsp_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .ctrl     (q_ctrl),
      .push_job (push_job),
      .stat     (q_stat),
      .head_job (head_job)
   );

   // Sequencer: single responses pass in one step, silence walks the table.
   vcsp_back u_back (
      .clock           (clock),
      .reset           (reset),
      .q_stat          (q_stat),
      .q_job           (head_job),
      .q_pop           (q_pop),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_event_res   (rsp_event_res),
      .rsp_reg_offset  (rsp_reg_offset),
      .rsp_reg_value   (rsp_reg_value),
      .rsp_seek_offset (rsp_seek_offset),
      .rsp_last        (rsp_last)
   );

endmodule

// ----- hw/rtl/vcsp_checker.sv -----
// Port-level checks for the command stream player, bound to the top level.
// Depends on vcsp_pkg and assert_macros.svh.
`include "assert_macros.svh"
module vcsp_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_ready,
   input logic [1:0]  req_kind,
   input logic [7:0]  req_stream_byte,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [1:0]  rsp_event_res,
   input logic [7:0]  rsp_reg_offset,
   input logic [7:0]  rsp_reg_value,
   input logic [31:0] rsp_seek_offset,
   input logic        rsp_last,
   input logic        csr_we,
   input logic [31:0] csr_wdata
);
   import vcsp_pkg::*;

   `VCSP_ASSERT(a_rsp_hold, rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_event_res) && $stable(rsp_reg_offset) && $stable(rsp_seek_offset) && $stable(rsp_last), "stalled response changed")
   `VCSP_ASSERT(a_non_write_clean, rsp_valid && rsp_event_res != EV_WRITE |-> rsp_reg_offset == 8'h00 && rsp_reg_value == 8'h00 && rsp_last, "non-write response malformed")
   `VCSP_ASSERT(a_seek_nonzero, rsp_valid && rsp_event_res == EV_SEEK |-> rsp_seek_offset != '0, "seek with zero offset")
   `VCSP_ASSERT(a_write_offset, rsp_valid && rsp_event_res == EV_WRITE |-> rsp_reg_offset != 8'h00 && rsp_seek_offset == '0, "write with bad offset")
   `VCSP_ASSERT_ALWAYS(a_reset_empty, reset |=> !rsp_valid, "response valid after reset")

endmodule

bind vgm_command_stream_player_core vcsp_checker u_checker (.*);
